// File: rtl/flv_pkg.sv
package flv_pkg;

  // Payload widths
  localparam int unsigned CH_W     = 8;
  localparam int unsigned FMT_W    = 3;
  localparam int unsigned ERR_W    = 3;
  localparam int unsigned SETS_W   = 3;
  localparam int unsigned TOK_W    = 3;
  localparam int unsigned DIV_W    = 4;
  localparam int unsigned SLASH_W  = 2;

  // Character codes
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;

  // Saturation limits
  localparam logic [TOK_W-1:0] TOK_MAX = 3'd7;
  localparam logic [DIV_W-1:0] DIV_MAX = 4'd15;

  // Face formats
  localparam logic [FMT_W-1:0] FMT_INVALID = 3'd0;
  localparam logic [FMT_W-1:0] FMT_VERTEX  = 3'd1;
  localparam logic [FMT_W-1:0] FMT_TEXTURE = 3'd2;
  localparam logic [FMT_W-1:0] FMT_NORMAL  = 3'd3;
  localparam logic [FMT_W-1:0] FMT_BOTH    = 3'd4;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE         = 3'd0;
  localparam logic [ERR_W-1:0] ERR_TOKENS       = 3'd1;
  localparam logic [ERR_W-1:0] ERR_MIXED        = 3'd2;
  localparam logic [ERR_W-1:0] ERR_TOO_MANY     = 3'd3;
  localparam logic [ERR_W-1:0] ERR_INCONSISTENT = 3'd4;
  localparam logic [ERR_W-1:0] ERR_COUNT        = 3'd5;
  localparam logic [ERR_W-1:0] ERR_EXTRA        = 3'd6;
  localparam logic [ERR_W-1:0] ERR_BOTH_COUNT   = 3'd7;

  // Token and divider counts that the format checks accept
  localparam logic [TOK_W-1:0] TOK_FOUR   = 3'd4;
  localparam logic [TOK_W-1:0] TOK_FIVE   = 3'd5;
  localparam logic [DIV_W-1:0] DIV_THREE  = 4'd3;
  localparam logic [DIV_W-1:0] DIV_FOUR   = 4'd4;
  localparam logic [DIV_W-1:0] DIV_SIX    = 4'd6;
  localparam logic [DIV_W-1:0] DIV_EIGHT  = 4'd8;

  // Slashes seen in the current index set
  localparam logic [SLASH_W-1:0] SLASH_NONE = 2'd0;
  localparam logic [SLASH_W-1:0] SLASH_ONE  = 2'd1;
  localparam logic [SLASH_W-1:0] SLASH_TWO  = 2'd2;

  typedef enum logic [1:0] {
    MODE_UNSET  = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_DOUBLE = 2'd2
  } div_mode_e;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
  } item_t;

  typedef struct packed {
    logic [FMT_W-1:0]  face_format;
    logic [ERR_W-1:0]  error_code;
    logic [SETS_W-1:0] set_count;
  } result_t;

  // Handshake between the input stage, core and result stage
  typedef struct packed {
    logic step;   // input stage word is consumed by the core this cycle
    logic load;   // result register takes a new word this cycle
  } flow_t;

endpackage

// File: rtl/flv_if.sv
interface flv_in_if;
  logic                      valid;
  logic                      ready;
  logic [flv_pkg::CH_W-1:0]  ch;
  logic                      last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface flv_out_if;
  logic                        valid;
  logic                        ready;
  logic [flv_pkg::FMT_W-1:0]   face_format;
  logic [flv_pkg::ERR_W-1:0]   error_code;
  logic [flv_pkg::SETS_W-1:0]  set_count;

  modport source (output valid, output face_format, output error_code, output set_count,
                  input ready);
  modport sink   (input valid, input face_format, input error_code, input set_count,
                  output ready);
endinterface

// File: rtl/obj_face_line_validator_unit.sv
// Channel  Dir  Payload                                  Word
// in_i     in   ch[7:0], last                            one line character
// res_o    out  face_format[2:0], error_code[2:0],       one verdict per line
//              set_count[2:0]
//
// Takes one character per cycle, unless a line's last character waits on a stalled result.
// Once the last character is accepted, the verdict goes from the input register,
// through the line state logic, into the result register.
// Reset clears the line state and both valid flags; no clearing pass.
// A stalled result holds only the last character of the next line; other
// characters keep flowing while a verdict waits.
module obj_face_line_validator_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  flv_in_if.sink    in_i,
  flv_out_if.source res_o
);

  logic              s1_valid;
  flv_pkg::item_t    s1_item;
  flv_pkg::result_t  core_res;
  flv_pkg::flow_t    flow;
  logic              out_free;

  // Consume the held character unless it ends a line and the result is blocked
  always_comb begin
    flow.step = s1_valid && (!s1_item.last || out_free);
    flow.load = flow.step && s1_item.last;
  end

  flv_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .step_i  (flow.step),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  flv_line_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (flow.step),
    .item_i  (s1_item),
    .res_o   (core_res)
  );

  flv_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (flow.load),
    .res_i   (core_res),
    .free_o  (out_free),
    .res_o   (res_o)
  );

endmodule

// File: rtl/flv_in_stage.sv
module flv_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  flv_in_if.sink           in_i,
  input  logic             step_i,
  output logic             valid_o,
  output flv_pkg::item_t   item_o
);

  logic           valid_q, valid_d;
  flv_pkg::item_t item_q;

  // Accept a word when the register is empty or drains this cycle
  assign in_i.ready = !valid_q || step_i;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.ch   <= in_i.ch;
      item_q.last <= in_i.last;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/flv_line_core.sv
module flv_line_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  flv_pkg::item_t   item_i,
  output flv_pkg::result_t res_o
);

  logic [flv_pkg::TOK_W-1:0]   tok_q, tok_d;
  logic                        has_q, has_d;
  logic                        prev_q, prev_d;
  logic                        first_q, first_d;
  logic [flv_pkg::DIV_W-1:0]   div_q, div_d;
  flv_pkg::div_mode_e          mode_q, mode_d;
  logic                        pend_q, pend_d;
  logic                        mixed_q, mixed_d;
  logic [flv_pkg::SLASH_W-1:0] slash_q, slash_d;
  logic                        both_q, both_d;
  logic [flv_pkg::ERR_W-1:0]   serr_q, serr_d;

  logic                        ws, sl;
  logic                        note_en;
  flv_pkg::div_mode_e          note_kind;
  logic [flv_pkg::TOK_W:0]     sum;
  logic [flv_pkg::TOK_W-1:0]   total;
  logic [flv_pkg::TOK_W-1:0]   total_m1;

  assign ws = (item_i.ch == flv_pkg::CH_SPACE) || (item_i.ch == flv_pkg::CH_TAB);
  assign sl = (item_i.ch == flv_pkg::CH_SLASH);

  // Token counting
  always_comb begin
    tok_d   = tok_q;
    has_d   = has_q;
    first_d = first_q;
    if (first_q) begin
      has_d   = !ws;
      first_d = 1'b0;
    end else if (ws && !prev_q) begin
      if (tok_q != flv_pkg::TOK_MAX) begin
        tok_d = tok_q + 3'd1;
      end
    end else if (!has_q && !ws) begin
      has_d = 1'b1;
    end
    prev_d = ws;
  end

  // Pair slashes into dividers; a slash left over at end of line is single
  always_comb begin
    note_en   = pend_q || (sl && item_i.last);
    note_kind = (sl && pend_q) ? flv_pkg::MODE_DOUBLE : flv_pkg::MODE_SINGLE;
    pend_d    = sl && !pend_q && !item_i.last;
    mixed_d   = mixed_q;
    div_d     = div_q;
    mode_d    = mode_q;
    if (note_en) begin
      if (mode_q != flv_pkg::MODE_UNSET && mode_q != note_kind) begin
        mixed_d = 1'b1;
      end
      if (div_q != flv_pkg::DIV_MAX) begin
        div_d = div_q + 4'd1;
      end
      mode_d = note_kind;
    end
  end

  // Slashes per set: a third slash flags too many; whitespace closing a set checks it against earlier sets
  always_comb begin
    slash_d = slash_q;
    both_d  = both_q;
    serr_d  = serr_q;
    if (serr_q == flv_pkg::ERR_NONE) begin
      if (sl) begin
        if (slash_q == flv_pkg::SLASH_NONE) begin
          slash_d = flv_pkg::SLASH_ONE;
        end else if (slash_q == flv_pkg::SLASH_TWO) begin
          serr_d = flv_pkg::ERR_TOO_MANY;
        end else begin
          slash_d = flv_pkg::SLASH_TWO;
        end
      end else if (ws) begin
        if (slash_q == flv_pkg::SLASH_TWO) begin
          both_d = 1'b1;
        end else if (both_q) begin
          serr_d = flv_pkg::ERR_INCONSISTENT;
        end
        slash_d = flv_pkg::SLASH_NONE;
      end
    end
  end

  // Line verdict in check priority order
  always_comb begin
    sum      = {1'b0, tok_d} + {{flv_pkg::TOK_W{1'b0}}, has_d};
    total    = sum[flv_pkg::TOK_W] ? flv_pkg::TOK_MAX : sum[flv_pkg::TOK_W-1:0];
    total_m1 = total - 3'd1;
    res_o.face_format = flv_pkg::FMT_INVALID;
    res_o.error_code  = flv_pkg::ERR_NONE;
    res_o.set_count   = (total == '0) ? '0 : total_m1;
    if (total != flv_pkg::TOK_FOUR && total != flv_pkg::TOK_FIVE) begin
      res_o.error_code = flv_pkg::ERR_TOKENS;
    end else if (div_d == '0) begin
      res_o.face_format = flv_pkg::FMT_VERTEX;
    end else if (mixed_d) begin
      res_o.error_code = flv_pkg::ERR_MIXED;
    end else if (mode_d == flv_pkg::MODE_SINGLE && serr_d != flv_pkg::ERR_NONE) begin
      res_o.error_code = serr_d;
    end else if (mode_d == flv_pkg::MODE_SINGLE && both_d) begin
      if ((total == flv_pkg::TOK_FOUR && div_d == flv_pkg::DIV_SIX) ||
          (total == flv_pkg::TOK_FIVE && div_d == flv_pkg::DIV_EIGHT)) begin
        res_o.face_format = flv_pkg::FMT_BOTH;
      end else begin
        res_o.error_code = flv_pkg::ERR_BOTH_COUNT;
      end
    end else if (div_d != flv_pkg::DIV_THREE && div_d != flv_pkg::DIV_FOUR) begin
      res_o.error_code = flv_pkg::ERR_COUNT;
    end else if (div_d != {1'b0, total_m1}) begin
      res_o.error_code = flv_pkg::ERR_EXTRA;
    end else begin
      res_o.face_format = (mode_d == flv_pkg::MODE_DOUBLE) ? flv_pkg::FMT_NORMAL
                                                           : flv_pkg::FMT_TEXTURE;
    end
  end

  // Advance line state; clear it at end of line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      has_q   <= 1'b0;
      prev_q  <= 1'b0;
      first_q <= 1'b1;
      div_q   <= '0;
      mode_q  <= flv_pkg::MODE_UNSET;
      pend_q  <= 1'b0;
      mixed_q <= 1'b0;
      slash_q <= flv_pkg::SLASH_NONE;
      both_q  <= 1'b0;
      serr_q  <= flv_pkg::ERR_NONE;
    end else if (step_i) begin
      if (item_i.last) begin
        tok_q   <= '0;
        has_q   <= 1'b0;
        prev_q  <= 1'b0;
        first_q <= 1'b1;
        div_q   <= '0;
        mode_q  <= flv_pkg::MODE_UNSET;
        pend_q  <= 1'b0;
        mixed_q <= 1'b0;
        slash_q <= flv_pkg::SLASH_NONE;
        both_q  <= 1'b0;
        serr_q  <= flv_pkg::ERR_NONE;
      end else begin
        tok_q   <= tok_d;
        has_q   <= has_d;
        prev_q  <= prev_d;
        first_q <= first_d;
        div_q   <= div_d;
        mode_q  <= mode_d;
        pend_q  <= pend_d;
        mixed_q <= mixed_d;
        slash_q <= slash_d;
        both_q  <= both_d;
        serr_q  <= serr_d;
      end
    end
  end

endmodule

// File: rtl/flv_out_stage.sv
module flv_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  flv_pkg::result_t  res_i,
  output logic              free_o,
  flv_out_if.source         res_o
);

  logic             valid_q, valid_d;
  flv_pkg::result_t res_q;

  // Register can take a word when empty or being read out
  assign free_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= res_i;
    end
  end

  assign res_o.valid       = valid_q;
  assign res_o.face_format = res_q.face_format;
  assign res_o.error_code  = res_q.error_code;
  assign res_o.set_count   = res_q.set_count;

endmodule

// File: rtl/flv_checker.sv
module flv_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        res_valid_i,
  input logic                        res_ready_i,
  input logic [flv_pkg::FMT_W-1:0]   face_format_i,
  input logic [flv_pkg::ERR_W-1:0]   error_code_i,
  input logic [flv_pkg::SETS_W-1:0]  set_count_i
);

  // Hold a stalled verdict word unchanged
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      res_valid_i && $stable(face_format_i) && $stable(error_code_i) && $stable(set_count_i))
    else $error("stalled verdict changed");

  // A verdict carries either a format or an error, never both
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> ((face_format_i == flv_pkg::FMT_INVALID) ==
                     (error_code_i != flv_pkg::ERR_NONE)))
    else $error("format and error code disagree");

  // Past the token check, the line has four or five tokens
  a_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && error_code_i != flv_pkg::ERR_TOKENS |->
      set_count_i == 3'd3 || set_count_i == 3'd4)
    else $error("set count inconsistent with token check");

  // A new verdict needs an accepted line end first; with none accepted, an empty result register stays empty
  a_nosrc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && in_ready_i) ##1 !(in_valid_i && in_ready_i) ##1
      !res_valid_i |=> !res_valid_i)
    else $error("verdict without a line end");

endmodule

bind obj_face_line_validator_unit flv_checker u_flv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .face_format_i (res_o.face_format),
  .error_code_i  (res_o.error_code),
  .set_count_i   (res_o.set_count)
);
